// ----- rtl/core/pkph_pkg.sv -----
// types, constants and tables for the position keyed pseudonoise hash
// no dependencies; the constant tables are built at elaboration

package pkph_pkg;

   localparam int unsigned PN_WIDTH    = 13;
   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned COORD_WIDTH = 16;
   localparam int unsigned SUM_WIDTH   = 24;

   typedef logic [PN_WIDTH-1:0]    pn_type;
   typedef logic [WORD_WIDTH-1:0]  word_type;
   typedef logic [COORD_WIDTH-1:0] coord_type;

   localparam logic [PN_WIDTH:0]   PN_POLY     = 14'h2b85;
   localparam pn_type              PN_PERIOD   = 13'd8191;
   localparam int unsigned         PN_STRIDE   = 256;
   localparam logic [SUM_WIDTH-1:0] Y_WEIGHT   = 24'd90;
   // smallest multiple of the period that keeps x + 90*y nonnegative
   localparam logic [SUM_WIDTH-1:0] POS_BIAS   = 24'd2989715;

   // column k of table row i is x^(2^i + k) mod poly
   typedef logic [PN_WIDTH-1:0][PN_WIDTH-1:0][PN_WIDTH-1:0] pow_cols_type;
   // entry b is x^(-256*b) mod poly
   typedef logic [WORD_WIDTH-1:0][PN_WIDTH-1:0] bit_wt_type;

   function automatic pn_type gf_mul(pn_type a, pn_type b);
      logic [PN_WIDTH:0] r;
      r = '0;
      for (int i = PN_WIDTH - 1; i >= 0; i--) begin
         r = {r[PN_WIDTH-1:0], 1'b0};
         if (r[PN_WIDTH]) begin
            r = r ^ PN_POLY;
         end
         if (b[i]) begin
            r = r ^ {1'b0, a};
         end
      end
      return r[PN_WIDTH-1:0];
   endfunction

   function automatic pn_type pn_state(pn_type k);
      pn_type r;
      pn_type base;
      r    = 13'd1;
      base = 13'd2;
      for (int i = 0; i < PN_WIDTH; i++) begin
         if (k[i]) begin
            r = gf_mul(r, base);
         end
         base = gf_mul(base, base);
      end
      return r;
   endfunction

   function automatic pow_cols_type build_pow_cols();
      pow_cols_type t;
      for (int i = 0; i < PN_WIDTH; i++) begin
         for (int k = 0; k < PN_WIDTH; k++) begin
            t[i][k] = pn_state(PN_WIDTH'((1 << i) + k));
         end
      end
      return t;
   endfunction

   function automatic bit_wt_type build_bit_wts();
      bit_wt_type t;
      for (int b = 0; b < WORD_WIDTH; b++) begin
         if (b == 0) begin
            t[b] = pn_state('0);
         end else begin
            t[b] = pn_state(PN_WIDTH'(int'(PN_PERIOD) - int'(PN_STRIDE) * b));
         end
      end
      return t;
   endfunction

   localparam pow_cols_type POW_COLS = build_pow_cols();
   localparam bit_wt_type   BIT_WTS  = build_bit_wts();

   // a * x^(2^i): linear map, xor of the selected table columns
   function automatic pn_type mul_pow2(pn_type a, int unsigned i);
      pn_type r;
      r = '0;
      for (int k = 0; k < PN_WIDTH; k++) begin
         if (a[k]) begin
            r = r ^ POW_COLS[i][k];
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/position_keyed_pn_hash_unit.sv -----
// position keyed pseudonoise hash, five stage pipeline
// depends on pkph_pkg for the field types, constants and lfsr tables
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_ready  req_data_word, req_pos_x, req_pos_y
//   rsp       out         rsp_valid/rsp_ready  rsp_check_value
//
// one request per cycle when rsp_ready stays high; each response leaves the last of
// the five register stages below
// the result is x^p times the xor of per-bit weights x^(-256*b), with
// p = (x + 90*y) mod 8191; the exponentiation is split over three stages
// reset clears the stage valid bits only; payload registers hold no reset
// a stall holds each full stage and lets empty stages behind it fill up

module position_keyed_pn_hash_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pkph_pkg::word_type  req_data_word,
   input  pkph_pkg::coord_type req_pos_x,
   input  pkph_pkg::coord_type req_pos_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pkph_pkg::pn_type    rsp_check_value
);
   import pkph_pkg::*;

   localparam int unsigned NUM_STAGES = 5;

   // stage valid bits and per-stage advance
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] move;

   // stage 1: biased position sum and word weight
   logic [SUM_WIDTH-2:0] sum_ff, sum_in;
   pn_type               wt_ff, wt_in;
   // stage 2: position reduced mod the period
   pn_type               p2_ff, p2_in;
   pn_type               acc2_ff, acc2_in;
   // stages 3 to 5: exponent bits applied a group at a time
   pn_type               p3_ff, p4_ff;
   pn_type               acc3_ff, acc3_in;
   pn_type               acc4_ff, acc4_in;
   pn_type               acc5_ff, acc5_in;

   logic signed [SUM_WIDTH-1:0] sx, sy, ssum;
   logic [PN_WIDTH:0]           fold1;
   pn_type                      fold2;

   // a stage takes new data when empty or when the stage after it moves
   always_comb begin
      move[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         move[k] = !vld_ff[k] || move[k+1];
      end
   end

   assign req_ready = move[0];

   always_comb begin
      vld_in[0] = req_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   // stage 1 logic: x + 90*y + bias is always in 0..2^23-1
   always_comb begin
      sx     = SUM_WIDTH'(signed'(req_pos_x));
      sy     = SUM_WIDTH'(signed'(req_pos_y));
      ssum   = sx + sy * signed'(Y_WEIGHT) + signed'(POS_BIAS);
      sum_in = ssum[SUM_WIDTH-2:0];
      wt_in  = '0;
      for (int b = 0; b < WORD_WIDTH; b++) begin
         if (req_data_word[b]) begin
            wt_in = wt_in ^ BIT_WTS[b];
         end
      end
   end

   // stage 2 logic: 2^13 is 1 mod 8191, so fold the high part onto the low
   always_comb begin
      fold1   = (PN_WIDTH+1)'(sum_ff[SUM_WIDTH-2:PN_WIDTH]) + {1'b0, sum_ff[PN_WIDTH-1:0]};
      fold2   = fold1[PN_WIDTH-1:0] + PN_WIDTH'(fold1[PN_WIDTH]);
      p2_in   = (fold2 == PN_PERIOD) ? '0 : fold2;
      acc2_in = wt_ff;
   end

   // stages 3 to 5: multiply by x^(2^i) for every set exponent bit
   always_comb begin
      acc3_in = acc2_ff;
      for (int i = 0; i < 4; i++) begin
         if (p2_ff[i]) begin
            acc3_in = mul_pow2(acc3_in, i);
         end
      end
      acc4_in = acc3_ff;
      for (int i = 4; i < 8; i++) begin
         if (p3_ff[i]) begin
            acc4_in = mul_pow2(acc4_in, i);
         end
      end
      acc5_in = acc4_ff;
      for (int i = 8; i < PN_WIDTH; i++) begin
         if (p4_ff[i]) begin
            acc5_in = mul_pow2(acc5_in, i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (move[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         sum_ff <= sum_in;
         wt_ff  <= wt_in;
      end
      if (move[1]) begin
         p2_ff   <= p2_in;
         acc2_ff <= acc2_in;
      end
      if (move[2]) begin
         p3_ff   <= p2_ff;
         acc3_ff <= acc3_in;
      end
      if (move[3]) begin
         p4_ff   <= p3_ff;
         acc4_ff <= acc4_in;
      end
      if (move[4]) begin
         acc5_ff <= acc5_in;
      end
   end

   assign rsp_valid       = vld_ff[NUM_STAGES-1];
   assign rsp_check_value = acc5_ff;

endmodule

// ----- sim/pn_hash_checker.sv -----
// response checker for the position keyed pseudonoise hash unit
// depends on pkph_pkg for the field types; predicts every response on its own
`timescale 1ns / 1ps

module pn_hash_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  pkph_pkg::word_type  req_data_word,
   input  pkph_pkg::coord_type req_pos_x,
   input  pkph_pkg::coord_type req_pos_y,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  pkph_pkg::pn_type    rsp_check_value,
   output int                  mismatch_count,
   output int                  backlog
);

   import pkph_pkg::*;

   localparam logic [13:0] LFSR_TAPS   = 14'h2b85;
   localparam int          SEQ_PERIOD  = 8191;
   localparam int          Y_SCALE     = 90;
   localparam int          BIT_STRIDE  = 256;

   pn_type pn_seq [0:SEQ_PERIOD-1];
   pn_type expected_checks [$];

   // walk the galois lfsr once through its whole period
   initial begin
      logic [13:0] lfsr;
      lfsr = 14'd1;
      for (int k = 0; k < SEQ_PERIOD; k++) begin
         pn_seq[k] = lfsr[12:0];
         lfsr = {lfsr[12:0], 1'b0};
         if (lfsr[13]) begin
            lfsr = lfsr ^ LFSR_TAPS;
         end
      end
   end

   function automatic pn_type predict_check_value(word_type w, coord_type x, coord_type y);
      int sum;
      int pos;
      int idx;
      pn_type acc;
      sum = int'($signed(x)) + Y_SCALE * int'($signed(y));
      pos = sum % SEQ_PERIOD;
      if (pos < 0) begin
         pos = pos + SEQ_PERIOD;
      end
      acc = '0;
      for (int b = 0; b < WORD_WIDTH; b++) begin
         if (w[b]) begin
            idx = (pos + SEQ_PERIOD - BIT_STRIDE * b) % SEQ_PERIOD;
            acc = acc ^ pn_seq[idx];
         end
      end
      return acc;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      pn_type want;
      if (reset) begin
         expected_checks.delete();
         mismatch_count = 0;
         backlog = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_checks.push_back(predict_check_value(req_data_word, req_pos_x, req_pos_y));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_checks.size() == 0) begin
               report_mismatch("unexpected response", int'(rsp_check_value), 0);
            end else begin
               want = expected_checks.pop_front();
               if (rsp_check_value !== want) begin
                  report_mismatch("check_value", int'(rsp_check_value), int'(want));
               end
            end
         end
         backlog = expected_checks.size();
      end
   end

endmodule

// ----- sim/tb.sv -----
// top level of the hash unit testbench: clock, reset, request stimulus and verdict
// depends on pkph_pkg, position_keyed_pn_hash_unit and pn_hash_checker
`timescale 1ns / 1ps

module tb;

   import pkph_pkg::*;

   // receiver stall patterns, picked again at random while the test runs
   typedef enum int {
      RDY_ALWAYS,
      RDY_RANDOM,
      RDY_PERIODIC,
      RDY_LONG_STALL
   } ready_mode_type;

   localparam int RANDOM_REQUESTS = 1700;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 20;
   localparam int MODE_SPAN       = 256;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   word_type  req_data_word = '0;
   coord_type req_pos_x = '0;
   coord_type req_pos_y = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   pn_type    rsp_check_value;

   int mismatch_count;
   int backlog;
   int idle_cycles = 0;

   // receiver pattern state
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             ready_cycle = 0;
   int             stall_left = 0;

   always #6 clock = ~clock;

   position_keyed_pn_hash_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_check_value (rsp_check_value)
   );

   pn_hash_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_check_value (rsp_check_value),
      .mismatch_count  (mismatch_count),
      .backlog         (backlog)
   );

   // watchdog: any cycle with no request or response accepted counts toward the limit
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // response side back-pressure, driven at the falling edge
   always @(negedge clock) begin
      ready_cycle = ready_cycle + 1;
      if (ready_cycle % MODE_SPAN == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
      end
      case (ready_mode)
         RDY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         RDY_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         RDY_PERIODIC: begin
            // ready low three eighths of the time, in a fixed repeating pattern
            rsp_ready <= ((ready_cycle % 8) >= 3);
         end
         default: begin
            // mostly ready, with an occasional long stall
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               stall_left = $urandom_range(5, 20);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // one request: optional gap with valid low, then hold until accepted
   // called at a falling edge and returns at a falling edge
   task automatic send_request(word_type w, coord_type x, coord_type y, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data_word <= w;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_valid     <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   // stop sending until every outstanding response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (backlog != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic word_type random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return word_type'(1) << $urandom_range(0, 31);
         3:       return ~(word_type'(1) << $urandom_range(0, 31));
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return coord_type'(int'($urandom_range(0, 200)) - 100);
         default: return coord_type'($urandom);
      endcase
   endfunction

   initial begin
      int burst_left;
      int gap;
      burst_left = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests: empty and full words, single bits, coordinate extremes,
      // and positions on either side of a multiple of the period
      send_request(32'h0000_0000, 16'h0000, 16'h0000, 0);
      send_request(32'h0000_0000, 16'h8000, 16'h8000, 0);
      send_request(32'hffff_ffff, 16'h0000, 16'h0000, 0);
      send_request(32'h0000_0001, 16'h0000, 16'h0000, 0);
      send_request(32'h8000_0000, 16'h0000, 16'h0000, 0);
      send_request(32'hffff_ffff, 16'h8000, 16'h8000, 0);
      send_request(32'hffff_ffff, 16'h7fff, 16'h7fff, 0);
      send_request(32'h8000_0001, 16'h8000, 16'h7fff, 0);
      send_request(32'h5555_5555, 16'h7fff, 16'h8000, 0);
      send_request(32'haaaa_aaaa, 16'hffff, 16'h0000, 0);
      send_request(32'h0000_0001, 16'h0000, 16'hffff, 0);
      send_request(32'h0000_0001, 16'd8190, 16'h0000, 0);
      send_request(32'h0000_0001, 16'd8191, 16'h0000, 0);
      send_request(32'h0000_0001, -16'sd8191, 16'h0000, 0);
      send_request(32'h0000_0001, -16'sd8192, 16'h0000, 0);
      send_request(32'h0000_0003, 16'h0000, 16'd91, 0);
      send_request(32'h0000_0003, 16'h0001, 16'd91, 0);
      send_request(32'hf0f0_0f0f, 16'hffff, -16'sd91, 0);
      send_request(32'h0001_0000, 16'h1234, 16'hedcb, 3);
      send_request(32'h7fff_ffff, 16'h0100, 16'h00ff, 1);

      // hold off the sender until the directed responses are all back
      drain_responses();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) begin
            drain_responses();
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // a quarter of the bursts follow the previous one with no gap
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         end else begin
            gap = 0;
         end
         burst_left = burst_left - 1;
         send_request(random_word(), random_coord(), random_coord(), gap);
      end
      req_valid <= 1'b0;

      while (backlog != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && backlog == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
